>>> design/sfc_pkg.sv
// Shared types, codes and helpers for the sphere/frustum classifier.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sfc_pkg;

  localparam int PLANES = 6;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KEYHOLE = 3'd7;

  localparam logic [1:0] LOC_OUTSIDE   = 2'd0;
  localparam logic [1:0] LOC_INTERSECT = 2'd1;
  localparam logic [1:0] LOC_INSIDE    = 2'd2;

  // coordinates in flight, wide enough for any lane reading
  localparam int CW = 17;
  localparam int DW = 36;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
    logic [14:0]          r;
    logic [1:0]           keyres;
    logic [1:0]           result;
    logic                 done;
  } item_t;

  // lane value: low 'bits' bits sign-extended; above 16 bits the lane is non-negative
  function automatic logic signed [CW-1:0] coord_ext(input logic [15:0] lane,
                                                     input int unsigned bits);
    logic [3:0]    sb;
    logic          sgn;
    logic [CW-1:0] res;
    sb  = (bits >= 16) ? 4'd15 : 4'(bits - 1);
    sgn = (bits <= 16) ? lane[sb] : 1'b0;
    for (int b = 0; b < CW; b++) begin
      if (b < bits) begin
        res[b] = (b < 16) ? lane[b[3:0]] : 1'b0;
      end else begin
        res[b] = sgn;
      end
    end
    return signed'(res);
  endfunction

endpackage

`default_nettype wire

>>> design/sfc_keyhole.sv
// Head of the cell chain: keyhole sphere test around the camera, three stages.
// Depends on sfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfc_keyhole
  import sfc_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [47:0] camera,
  input  wire logic [15:0] keyhole,
  input  wire logic        up_valid,
  output logic             up_stall,
  input  wire logic [15:0] cx,
  input  wire logic [15:0] cy,
  input  wire logic [15:0] cz,
  input  wire logic [14:0] r,
  input  wire logic        ign,
  output logic             dn_valid,
  input  wire logic        dn_stall,
  output item_t            dn_item
);

  logic s1_v, s2_v, s3_v;
  logic mv1, mv2, mv3;

  // stage 1: differences and limit terms
  item_t s1_item;
  logic signed [17:0] s1_d0, s1_d1, s1_d2;
  logic signed [17:0] s1_rpk, s1_kmr;
  logic s1_en;

  // stage 2: squares
  item_t s2_item;
  logic signed [35:0] s2_q0, s2_q1, s2_q2;
  logic signed [35:0] s2_lim_out, s2_lim_in;
  logic s2_en;

  logic signed [CW-1:0] c0, c1, c2, k;
  logic signed [37:0]   d2;
  logic [1:0]           kres;
  item_t                dn_item_next;

  assign mv3 = !s3_v || !dn_stall;
  assign mv2 = !s2_v || mv3;
  assign mv1 = !s1_v || mv2;
  assign up_stall = !mv1;
  assign dn_valid = s3_v;

  assign c0 = coord_ext(cx, COORD_BITS);
  assign c1 = coord_ext(cy, COORD_BITS);
  assign c2 = coord_ext(cz, COORD_BITS);
  assign k  = coord_ext(keyhole, COORD_BITS);

  assign d2 = 38'(s2_q0) + 38'(s2_q1) + 38'(s2_q2);

  always_comb begin
    if (!s2_en) begin
      kres = LOC_OUTSIDE;
    end else if (d2 > 38'(s2_lim_out)) begin
      kres = LOC_OUTSIDE;
    end else if (d2 < 38'(s2_lim_in)) begin
      kres = LOC_INSIDE;
    end else begin
      kres = LOC_INTERSECT;
    end
  end

  always_comb begin
    dn_item_next        = s2_item;
    dn_item_next.keyres = kres;
    dn_item_next.result = LOC_INSIDE;
    dn_item_next.done   = (kres == LOC_INSIDE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      if (mv1) s1_v <= up_valid;
      if (mv2) s2_v <= s1_v;
      if (mv3) s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (mv1) begin
      s1_item.cx     <= c0;
      s1_item.cy     <= c1;
      s1_item.cz     <= c2;
      s1_item.r      <= r;
      s1_item.keyres <= LOC_OUTSIDE;
      s1_item.result <= LOC_INSIDE;
      s1_item.done   <= 1'b0;
      s1_d0  <= 18'(c0) - 18'(coord_ext(camera[15:0], COORD_BITS));
      s1_d1  <= 18'(c1) - 18'(coord_ext(camera[31:16], COORD_BITS));
      s1_d2  <= 18'(c2) - 18'(coord_ext(camera[47:32], COORD_BITS));
      s1_rpk <= $signed({3'b000, r}) + 18'(k);
      s1_kmr <= 18'(k) - $signed({3'b000, r});
      s1_en  <= !ign && !k[CW-1];
    end
    if (mv2) begin
      s2_item    <= s1_item;
      s2_q0      <= s1_d0 * s1_d0;
      s2_q1      <= s1_d1 * s1_d1;
      s2_q2      <= s1_d2 * s1_d2;
      s2_lim_out <= s1_rpk * s1_rpk;
      s2_lim_in  <= (s1_kmr > 18'sd0) ? s1_kmr * s1_kmr : 36'sd0;
      s2_en      <= s1_en;
    end
    if (mv3) begin
      dn_item <= dn_item_next;
    end
  end

endmodule

`default_nettype wire

>>> design/sfc_plane_cell.sv
// One plane cell: holds its plane word, forms the signed distance and updates the word.
// Depends on sfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfc_plane_cell
  import sfc_pkg::*;
#(
  parameter int COORD_BITS  = 16,
  parameter int PLANE_INDEX = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [63:0]          wr_data,
  input  wire logic                 up_valid,
  output logic                      up_stall,
  input  wire item_t                up_item,
  output logic                      dn_valid,
  input  wire logic                 dn_stall,
  output item_t                     dn_item
);

  logic [63:0] plane;

  logic sa_v, sb_v;
  logic mva, mvb;

  item_t sa_item;
  logic signed [32:0] sa_p0, sa_p1, sa_p2;
  logic signed [30:0] sa_off;

  logic signed [DW-1:0] distance, rs;
  item_t                dn_item_next;

  assign mvb = !sb_v || !dn_stall;
  assign mva = !sa_v || mvb;
  assign up_stall = !mva;
  assign dn_valid = sb_v;

  assign distance = DW'(sa_p0) + DW'(sa_p1) + DW'(sa_p2) + DW'(sa_off);
  assign rs       = signed'(DW'({sa_item.r, 14'b0}));

  always_comb begin
    dn_item_next = sa_item;
    if (!sa_item.done) begin
      if (distance < -rs) begin
        dn_item_next.result = sa_item.keyres;
        dn_item_next.done   = 1'b1;
      end else if (distance < rs) begin
        dn_item_next.result = LOC_INTERSECT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane <= '0;
      sa_v  <= 1'b0;
      sb_v  <= 1'b0;
    end else begin
      if (wr_en && wr_index == CFG_IDX_W'(PLANE_INDEX)) plane <= wr_data;
      if (mva) sa_v <= up_valid;
      if (mvb) sb_v <= sa_v;
    end
  end

  always_ff @(posedge clk) begin
    if (mva) begin
      sa_item <= up_item;
      sa_p0   <= $signed(plane[15:0])  * up_item.cx;
      sa_p1   <= $signed(plane[31:16]) * up_item.cy;
      sa_p2   <= $signed(plane[47:32]) * up_item.cz;
      sa_off  <= {coord_ext(plane[63:48], COORD_BITS), 14'b0};
    end
    if (mvb) begin
      dn_item <= dn_item_next;
    end
  end

endmodule

`default_nettype wire

>>> design/sphere_frustum_classify.sv
// Sphere classifier against six view planes and an optional keyhole sphere
// around the camera. Fully pipelined: one word accepted per cycle unless
// item_stall is high; three keyhole stages, then two stages in each of six
// plane cells. Stall on the result side holds only the words that cannot advance.
// Configuration: wr_index 0..5 planes, 6 camera position, 7 keyhole radius.
// Depends on sfc_pkg, sfc_keyhole and sfc_plane_cell.
`timescale 1ns / 1ps
`default_nettype none

module sphere_frustum_classify
  import sfc_pkg::*;
#(
  parameter int COORD_BITS  = 16,
  parameter int PLANE_COUNT = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [63:0]          wr_data,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire logic [15:0]          center_x,
  input  wire logic [15:0]          center_y,
  input  wire logic [15:0]          center_z,
  input  wire logic [14:0]          sphere_radius,
  input  wire logic                 ignore_keyhole,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output logic [1:0]                location
);

  logic [47:0] camera;
  logic [15:0] keyhole;

  logic  ch_valid [PLANE_COUNT+1];
  logic  ch_stall [PLANE_COUNT+1];
  item_t ch_item  [PLANE_COUNT+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      camera  <= '0;
      keyhole <= 16'hFFF0;
    end else if (wr_en) begin
      if (wr_index == REG_CAMERA)  camera  <= wr_data[47:0];
      if (wr_index == REG_KEYHOLE) keyhole <= wr_data[15:0];
    end
  end

  sfc_keyhole #(
    .COORD_BITS(COORD_BITS)
  ) u_keyhole (
    .clk      (clk),
    .rst      (rst),
    .camera   (camera),
    .keyhole  (keyhole),
    .up_valid (item_valid),
    .up_stall (item_stall),
    .cx       (center_x),
    .cy       (center_y),
    .cz       (center_z),
    .r        (sphere_radius),
    .ign      (ignore_keyhole),
    .dn_valid (ch_valid[0]),
    .dn_stall (ch_stall[0]),
    .dn_item  (ch_item[0])
  );

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_cell
    sfc_plane_cell #(
      .COORD_BITS  (COORD_BITS),
      .PLANE_INDEX (p)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (wr_en),
      .wr_index (wr_index),
      .wr_data  (wr_data),
      .up_valid (ch_valid[p]),
      .up_stall (ch_stall[p]),
      .up_item  (ch_item[p]),
      .dn_valid (ch_valid[p+1]),
      .dn_stall (ch_stall[p+1]),
      .dn_item  (ch_item[p+1])
    );
  end

  assign ch_stall[PLANE_COUNT] = result_stall;
  assign result_valid = ch_valid[PLANE_COUNT];
  assign location     = ch_item[PLANE_COUNT].result;

endmodule

`default_nettype wire

>>> sim/sphere_frustum_classify_test.sv
// Self-checking testbench for sphere_frustum_classify: predicts each location
// word from its own copy of the planes, camera and keyhole and checks it in order.
// Depends on sfc_pkg and the sphere_frustum_classify RTL.
`timescale 1ns / 1ps

module sphere_frustum_classify_test;
  import sfc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_PAUSE    = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int BOX_AXIS [PLANES] = '{1, 1, 0, 0, 2, 2};
  localparam bit BOX_NEG  [PLANES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [14:0]        radius;
    logic               skip_keyhole;
  } sphere_t;

  typedef struct packed {
    logic [PLANES-1:0][63:0] planes;
    logic [47:0]             camera;
    logic [15:0]             keyhole;
  } view_cfg_t;

  logic                 clk;
  logic                 rst;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [63:0]          wr_data;
  logic                 item_valid;
  logic                 item_stall;
  logic [15:0]          center_x;
  logic [15:0]          center_y;
  logic [15:0]          center_z;
  logic [14:0]          sphere_radius;
  logic                 ignore_keyhole;
  logic                 result_valid;
  logic                 result_stall;
  logic [1:0]           location;

  view_cfg_t  live_cfg;
  logic [1:0] expected_locations [$];
  logic [1:0] want_location;
  int         mismatches = 0;
  int         results_seen = 0;
  int         stuck_cycles = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_request = 0;
  int         hold_left = 0;

  sphere_frustum_classify dut (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .center_x       (center_x),
    .center_y       (center_y),
    .center_z       (center_z),
    .sphere_radius  (sphere_radius),
    .ignore_keyhole (ignore_keyhole),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .location       (location)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [1:0] predict_location(input sphere_t s);
    longint             c [3];
    longint             r, k, d2, diff, distance, rs;
    logic signed [15:0] lane;
    logic [1:0]         keyres, res;
    c[0] = longint'(signed'(s.x));
    c[1] = longint'(signed'(s.y));
    c[2] = longint'(signed'(s.z));
    r = longint'(s.radius);
    k = longint'(signed'(live_cfg.keyhole));
    keyres = LOC_OUTSIDE;
    if (!s.skip_keyhole && k >= 0) begin
      d2 = 0;
      for (int i = 0; i < 3; i++) begin
        lane = live_cfg.camera[16*i +: 16];
        diff = c[i] - lane;
        d2 += diff * diff;
      end
      if (d2 > (r + k) * (r + k)) keyres = LOC_OUTSIDE;
      else if (k - r > 0 && d2 < (k - r) * (k - r)) keyres = LOC_INSIDE;
      else keyres = LOC_INTERSECT;
    end
    if (keyres == LOC_INSIDE) return LOC_INSIDE;
    res = LOC_INSIDE;
    rs = r * 16384;
    for (int p = 0; p < PLANES; p++) begin
      lane = live_cfg.planes[p][63:48];
      distance = longint'(lane) * 16384;
      for (int i = 0; i < 3; i++) begin
        lane = live_cfg.planes[p][16*i +: 16];
        distance += longint'(lane) * c[i];
      end
      if (distance < -rs) return keyres;
      else if (distance < rs) res = LOC_INTERSECT;
    end
    return res;
  endfunction

  function automatic sphere_t sphere_at(input int x, input int y, input int z,
                                        input int r, input bit skip);
    sphere_t s;
    s.x = 16'(x);
    s.y = 16'(y);
    s.z = 16'(z);
    s.radius = 15'(r);
    s.skip_keyhole = skip;
    return s;
  endfunction

  // axis-aligned plane facing along +/- axis, normals jittered
  function automatic logic [63:0] make_plane(input int axis, input bit neg,
                                             input int offset, input int jitter);
    logic [63:0] pl;
    int          n;
    for (int i = 0; i < 3; i++) begin
      n = (i == axis) ? (neg ? -16384 : 16384) : 0;
      n += int'($urandom_range(0, 2 * jitter)) - jitter;
      pl[16*i +: 16] = 16'(n);
    end
    pl[63:48] = 16'(offset);
    return pl;
  endfunction

  function automatic view_cfg_t make_view(input bit scrambled);
    view_cfg_t v;
    int        jitter;
    jitter = $urandom_range(0, 1500);
    for (int p = 0; p < PLANES; p++) begin
      if (scrambled) v.planes[p] = {$urandom, $urandom};
      else v.planes[p] = make_plane(BOX_AXIS[p], BOX_NEG[p], $urandom_range(200, 4000), jitter);
    end
    if (scrambled) begin
      v.camera = {16'($urandom), $urandom};
      v.keyhole = 16'($urandom);
    end else begin
      for (int i = 0; i < 3; i++) v.camera[16*i +: 16] = 16'(int'($urandom_range(0, 8000)) - 4000);
      case ($urandom_range(0, 3))
        0: v.keyhole = 16'(-int'($urandom_range(1, 32768)));
        1: v.keyhole = 16'd0;
        2: v.keyhole = 16'($urandom_range(1, 800));
        default: v.keyhole = 16'($urandom_range(800, 4000));
      endcase
    end
    return v;
  endfunction

  // mostly spheres around the box and around the camera, some raw words
  function automatic sphere_t make_sphere();
    sphere_t s;
    int      pick, spread;
    pick = $urandom_range(0, 99);
    s.radius = ($urandom_range(0, 3) == 0) ? 15'd0 : 15'($urandom_range(0, 1500));
    s.skip_keyhole = ($urandom_range(0, 3) == 0);
    if (pick < 60) begin
      s.x = 16'(int'($urandom_range(0, 12000)) - 6000);
      s.y = 16'(int'($urandom_range(0, 12000)) - 6000);
      s.z = 16'(int'($urandom_range(0, 12000)) - 6000);
    end else if (pick < 85) begin
      spread = 1200 + (live_cfg.keyhole[15] ? 0 : int'(live_cfg.keyhole[14:0]));
      s.x = 16'(int'(signed'(live_cfg.camera[15:0])) + int'($urandom_range(0, 2 * spread)) - spread);
      s.y = 16'(int'(signed'(live_cfg.camera[31:16])) + int'($urandom_range(0, 2 * spread)) - spread);
      s.z = 16'(int'(signed'(live_cfg.camera[47:32])) + int'($urandom_range(0, 2 * spread)) - spread);
    end else begin
      s = sphere_t'({$urandom, $urandom});
    end
    return s;
  endfunction

  task automatic send_sphere(input sphere_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid     <= 1'b1;
    center_x       <= s.x;
    center_y       <= s.y;
    center_z       <= s.z;
    sphere_radius  <= s.radius;
    ignore_keyhole <= s.skip_keyhole;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    expected_locations.push_back(predict_location(s));
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (expected_locations.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // upper data bits beyond the camera and keyhole register widths carry junk on purpose
  task automatic apply_config(input view_cfg_t cfg);
    for (int p = 0; p < PLANES; p++) begin
      wr_en    <= 1'b1;
      wr_index <= CFG_IDX_W'(p);
      wr_data  <= cfg.planes[p];
      @(posedge clk);
      live_cfg.planes[p] = cfg.planes[p];
    end
    wr_index <= REG_CAMERA;
    wr_data  <= {16'($urandom), cfg.camera};
    @(posedge clk);
    live_cfg.camera = cfg.camera;
    wr_index <= REG_KEYHOLE;
    wr_data  <= {16'($urandom), $urandom, cfg.keyhole};
    @(posedge clk);
    live_cfg.keyhole = cfg.keyhole;
    wr_en <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // planes all zero, keyhole disabled
  task automatic test_reset_defaults();
    send_sphere(sphere_at(0, 0, 0, 0, 1'b0));
    send_sphere(sphere_at(0, 0, 0, 5, 1'b0));
    send_sphere(sphere_at(-32768, 32767, -32768, 32767, 1'b0));
    send_sphere(sphere_at(32767, -32768, 32767, 0, 1'b1));
    send_sphere(sphere_at(16'h5555, 16'hAAAA, 16'h5555, 15'h2AAA, 1'b1));
    send_sphere(sphere_at(16'hAAAA, 16'h5555, 16'hAAAA, 15'h5555, 1'b0));
  endtask

  // box of half size 100.0 with unit normals, camera at x = 200.0, keyhole 20.0
  task automatic test_box_boundaries();
    view_cfg_t box;
    for (int p = 0; p < PLANES; p++) box.planes[p] = make_plane(BOX_AXIS[p], BOX_NEG[p], 1600, 0);
    box.camera  = {16'd0, 16'd0, 16'd3200};
    box.keyhole = 16'd320;
    wait_drained();
    apply_config(box);
    send_sphere(sphere_at(-1616, 0, 0, 16, 1'b1));
    send_sphere(sphere_at(-1617, 0, 0, 16, 1'b1));
    send_sphere(sphere_at(-1584, 0, 0, 16, 1'b1));
    send_sphere(sphere_at(-1585, 0, 0, 16, 1'b1));
    send_sphere(sphere_at(0, -1600, 0, 0, 1'b1));
    send_sphere(sphere_at(0, 0, -1601, 0, 1'b1));
    send_sphere(sphere_at(0, 0, 0, 32767, 1'b1));
    send_sphere(sphere_at(1616, 0, 0, 16, 1'b1));
  endtask

  task automatic test_keyhole_boundaries();
    send_sphere(sphere_at(3200, 0, 0, 0, 1'b0));
    send_sphere(sphere_at(3536, 0, 0, 16, 1'b0));
    send_sphere(sphere_at(3537, 0, 0, 16, 1'b0));
    send_sphere(sphere_at(3504, 0, 0, 16, 1'b0));
    send_sphere(sphere_at(3503, 0, 0, 16, 1'b0));
    send_sphere(sphere_at(3200, 0, 0, 400, 1'b0));
    send_sphere(sphere_at(3200, 0, 0, 0, 1'b1));
  endtask

  task automatic test_random_traffic(input int views, input int per_view);
    for (int v = 0; v < views; v++) begin
      wait_drained();
      apply_config(make_view($urandom_range(0, 3) == 0));
      repeat (per_view) send_sphere(make_sphere());
    end
  endtask

  task automatic test_extreme_config();
    view_cfg_t cfg;
    for (int e = 0; e < 3; e++) begin
      case (e)
        0: begin
          cfg.planes  = {PLANES{64'h8000_8000_8000_8000}};
          cfg.camera  = 48'h8000_7FFF_8000;
          cfg.keyhole = 16'h7FFF;
        end
        1: begin
          cfg.planes  = {PLANES{64'h7FFF_7FFF_7FFF_7FFF}};
          cfg.camera  = 48'h7FFF_8000_7FFF;
          cfg.keyhole = 16'h8000;
        end
        default: begin
          cfg.planes  = {PLANES{64'hFFFF_FFFF_FFFF_FFFF}};
          cfg.camera  = 48'h0;
          cfg.keyhole = 16'h0000;
        end
      endcase
      wait_drained();
      apply_config(cfg);
      repeat (30) send_sphere(make_sphere());
    end
  endtask

  // result side held off while words keep coming, so the pipe backs up
  task automatic test_backpressure();
    hold_request = HOLD_CYCLES;
    repeat (80) send_sphere(make_sphere());
  endtask

  task automatic test_sender_pause();
    repeat (30) send_sphere(make_sphere());
    wait_drained();
    repeat (30) send_sphere(make_sphere());
  endtask

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (expected_locations.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: location %0d with no word pending", results_seen, location);
      end else begin
        want_location = expected_locations.pop_front();
        if (location !== want_location) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: location expected %0d, got %0d",
                     results_seen, want_location, location);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) || wr_en)
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("no handshake for %0d cycles", stuck_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    wr_en          = 1'b0;
    wr_index       = '0;
    wr_data        = '0;
    item_valid     = 1'b0;
    center_x       = '0;
    center_y       = '0;
    center_z       = '0;
    sphere_radius  = '0;
    ignore_keyhole = 1'b0;
    result_stall   = 1'b0;
    live_cfg.planes  = '0;
    live_cfg.camera  = '0;
    live_cfg.keyhole = 16'hFFF0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_idling(36, 80);
    test_reset_defaults();
    test_box_boundaries();
    test_keyhole_boundaries();
    test_random_traffic(4, 100);

    set_idling(80, 36);
    test_extreme_config();
    test_random_traffic(4, 100);

    set_idling(0, 0);
    test_backpressure();
    test_sender_pause();
    test_random_traffic(3, 100);

    wait_drained();
    if (mismatches == 0 && expected_locations.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
